// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hw/rtl/pse_pkg.sv
// Package: constants, types and state encoding of the prime sieve enumerator.
package pse_pkg;

    localparam int MAX_LIMIT   = 1024;
    localparam int ADDR_W      = $clog2(MAX_LIMIT);
    localparam int LIM_W       = ADDR_W + 1;
    localparam int CFG_W       = 11;
    localparam int PRIME_W     = 10;
    localparam int FIRST_PRIME = 2;
    localparam logic [CFG_W-1:0] LIMIT_RST = CFG_W'(1024);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SV_RD,
        ST_SV_CHK,
        ST_CLR,
        ST_SCAN,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic [PRIME_W-1:0] prime;
        logic               done;
        logic               last;
    } t_result;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

// File: hw/rtl/pse_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
module pse_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/pse_ctrl.sv
// Sequencer: sieve rebuild (fill, mark, clear) and pipelined scan of the flag RAM.
module pse_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_restart,
    input  logic [pse_pkg::LIM_W-1:0] i_limit,
    output logic                     o_idle,
    input  logic                     i_rdata,
    output pse_pkg::t_mem_req        o_mem,
    output logic                     o_res_valid,
    input  logic                     i_res_take,
    output pse_pkg::t_result         o_res
);

    localparam int LW = pse_pkg::LIM_W;
    localparam int AW = pse_pkg::ADDR_W;
    localparam logic [LW-1:0] FIRST = LW'(pse_pkg::FIRST_PRIME);

    pse_pkg::t_state  r_state, n_state;
    logic             r_built, n_built;
    logic [LW-1:0]    r_blim, n_blim;
    logic [LW-1:0]    r_cursor, n_cursor;
    logic [LW-1:0]    r_idx, n_idx;
    logic [LW-1:0]    r_pos, n_pos;
    logic             r_chk_vld, n_chk_vld;
    logic [LW-1:0]    r_chk_addr, n_chk_addr;
    logic             r_have_p, n_have_p;
    logic [LW-1:0]    r_p, n_p;
    pse_pkg::t_result r_res, n_res;

    logic            rebuild_req;
    logic [2*LW-1:0] sq;
    logic            sieve_end;
    logic            pos_in;
    logic [LW:0]     step;
    logic            clr_last;
    logic            hit;
    logic            scan_fin;
    logic [LW-1:0]   cur_start;

    assign rebuild_req = i_restart | ~r_built;
    assign sq          = r_idx * r_idx;
    assign sieve_end   = sq >= (2*LW)'(r_blim);
    assign pos_in      = r_pos < r_blim;
    assign step        = {1'b0, r_pos} + {1'b0, r_idx};
    assign clr_last    = step >= {1'b0, r_blim};
    assign hit         = r_chk_vld & i_rdata;
    // finish on the second marked entry, or once the scan has run off the limit
    assign scan_fin    = (hit & r_have_p) | ~pos_in;
    assign cur_start   = (r_cursor < FIRST) ? FIRST : r_cursor;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pse_pkg::ST_IDLE: begin
                if (i_start) n_state = rebuild_req ? pse_pkg::ST_FILL : pse_pkg::ST_SCAN;
            end
            pse_pkg::ST_FILL:   if (!pos_in) n_state = pse_pkg::ST_SV_RD;
            pse_pkg::ST_SV_RD:  n_state = sieve_end ? pse_pkg::ST_SCAN : pse_pkg::ST_SV_CHK;
            pse_pkg::ST_SV_CHK: n_state = i_rdata ? pse_pkg::ST_CLR : pse_pkg::ST_SV_RD;
            pse_pkg::ST_CLR:    if (clr_last) n_state = pse_pkg::ST_SV_RD;
            pse_pkg::ST_SCAN:   if (scan_fin) n_state = pse_pkg::ST_RESP;
            pse_pkg::ST_RESP:   if (i_res_take) n_state = pse_pkg::ST_IDLE;
            default:            n_state = pse_pkg::ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        n_built    = r_built;
        n_blim     = r_blim;
        n_cursor   = r_cursor;
        n_idx      = r_idx;
        n_pos      = r_pos;
        n_chk_vld  = r_chk_vld;
        n_chk_addr = r_chk_addr;
        n_have_p   = r_have_p;
        n_p        = r_p;
        n_res      = r_res;
        unique case (r_state)
            pse_pkg::ST_IDLE: begin
                n_chk_vld = 1'b0;
                n_have_p  = 1'b0;
                if (i_start) begin
                    if (rebuild_req) begin
                        n_blim   = i_limit;
                        n_built  = 1'b1;
                        n_cursor = FIRST;
                        n_pos    = FIRST;
                    end else begin
                        n_pos = cur_start;
                    end
                end
            end
            pse_pkg::ST_FILL: begin
                if (pos_in) begin
                    n_pos = r_pos + LW'(1);
                end else begin
                    n_idx = FIRST;
                end
            end
            pse_pkg::ST_SV_RD: begin
                if (sieve_end) begin
                    n_pos     = FIRST;
                    n_chk_vld = 1'b0;
                    n_have_p  = 1'b0;
                end
            end
            pse_pkg::ST_SV_CHK: begin
                // clearing starts at i*i, which lies below the limit here
                if (i_rdata) begin
                    n_pos = sq[LW-1:0];
                end else begin
                    n_idx = r_idx + LW'(1);
                end
            end
            pse_pkg::ST_CLR: begin
                n_pos = step[LW-1:0];
                if (clr_last) begin
                    n_idx = r_idx + LW'(1);
                end
            end
            pse_pkg::ST_SCAN: begin
                n_chk_vld  = pos_in;
                n_chk_addr = r_pos;
                if (pos_in) begin
                    n_pos = r_pos + LW'(1);
                end
                if (hit && !r_have_p) begin
                    n_have_p = 1'b1;
                    n_p      = r_chk_addr;
                end
                if (scan_fin) begin
                    if (r_have_p || hit) begin
                        n_res.prime = pse_pkg::PRIME_W'(r_have_p ? r_p : r_chk_addr);
                        n_res.done  = 1'b0;
                        n_res.last  = ~(hit & r_have_p);
                        // resume at the look-ahead prime; nothing marked lies between
                        n_cursor    = (hit && r_have_p) ? r_chk_addr : r_blim;
                    end else begin
                        n_res.prime = '0;
                        n_res.done  = 1'b1;
                        n_res.last  = 1'b0;
                        n_cursor    = r_blim;
                    end
                end
            end
            pse_pkg::ST_RESP: begin
                n_chk_vld = 1'b0;
            end
            default: begin
                n_chk_vld = 1'b0;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_mem       = '0;
        o_idle      = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            pse_pkg::ST_IDLE:   o_idle = 1'b1;
            pse_pkg::ST_FILL: begin
                o_mem.we    = pos_in;
                o_mem.waddr = r_pos[AW-1:0];
                o_mem.wdata = 1'b1;
            end
            pse_pkg::ST_SV_RD:  o_mem.raddr = r_idx[AW-1:0];
            pse_pkg::ST_SV_CHK: o_mem.raddr = r_idx[AW-1:0];
            pse_pkg::ST_CLR: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_pos[AW-1:0];
                o_mem.wdata = 1'b0;
            end
            pse_pkg::ST_SCAN:   o_mem.raddr = r_pos[AW-1:0];
            pse_pkg::ST_RESP:   o_res_valid = 1'b1;
            default:            o_idle = 1'b0;
        endcase
    end

    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pse_pkg::ST_IDLE;
            r_built   <= 1'b0;
            r_blim    <= '0;
            r_cursor  <= FIRST;
            r_chk_vld <= 1'b0;
            r_have_p  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_built   <= n_built;
            r_blim    <= n_blim;
            r_cursor  <= n_cursor;
            r_chk_vld <= n_chk_vld;
            r_have_p  <= n_have_p;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_pos      <= n_pos;
        r_chk_addr <= n_chk_addr;
        r_p        <= n_p;
        r_res      <= n_res;
    end

endmodule

// File: hw/rtl/prime_sieve_enumerator.sv
// Without rebuild, a request scans from the cursor to the prime after the one returned,
//   then the result goes into the output register.
// With rebuild: fill up to the limit, then a flag read and check per sieve base below
//   sqrt(limit) plus a clear per multiple of each prime base, then the scan.
// One request at a time; next request taken once result is registered.
// Reset: synchronous, active low; limit returns to 1024, no sieve held, flag RAM not cleared.
// Top level: prime sieve enumerator.
`include "assert_macros.svh"

module prime_sieve_enumerator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // request channel
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_restart,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pse_pkg::PRIME_W-1:0] o_prime_value,
    output logic                        o_done_res,
    output logic                        o_last_prime,
    // configuration
    input  logic                        i_cfg_we,
    input  logic [pse_pkg::CFG_W-1:0]   i_cfg_wdata
);

    localparam int LW = pse_pkg::LIM_W;

    logic [pse_pkg::CFG_W-1:0] r_limit;
    logic [LW-1:0]             lim_sat;
    logic                      start;
    logic                      idle;
    logic                      rdata;
    pse_pkg::t_mem_req         mem_req;
    logic                      res_valid;
    logic                      res_take;
    pse_pkg::t_result          res;
    logic                      r_out_vld;
    pse_pkg::t_result          r_out;

    // Limit register; only sampled by the sequencer when a rebuild starts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= pse_pkg::LIMIT_RST;
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_wdata;
        end
    end

    // saturate to the flag RAM depth
    assign lim_sat = (32'(r_limit) > 32'(pse_pkg::MAX_LIMIT)) ?
                     LW'(pse_pkg::MAX_LIMIT) : LW'(r_limit);

    assign o_in_ready = idle;
    assign start      = i_in_valid & idle;

    pse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_restart   (i_restart),
        .i_limit     (lim_sat),
        .o_idle      (idle),
        .i_rdata     (rdata),
        .o_mem       (mem_req),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res)
    );

    // One flag per candidate. Phases never overlap a write and a read of the
    // same entry, so no forwarding path is needed.
    pse_ram #(
        .WIDTH (1),
        .DEPTH (pse_pkg::MAX_LIMIT)
    ) u_flags (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_raddr (mem_req.raddr),
        .o_rdata (rdata)
    );

    // Output register: the next request is taken while a result still waits.
    assign res_take = res_valid & (~r_out_vld | i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_take) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_prime_value = r_out.prime;
    assign o_done_res    = r_out.done;
    assign o_last_prime  = r_out.last;

    // a done result carries no prime and no last flag
    `ASSERT_CLK(a_done_clean, i_clk, i_rst_n, o_out_valid && o_done_res |-> o_prime_value == '0 && !o_last_prime, "done result with prime or last flag")
    // a prime is never below two
    `ASSERT_CLK(a_prime_min, i_clk, i_rst_n, o_out_valid && !o_done_res |-> o_prime_value >= pse_pkg::PRIME_W'(pse_pkg::FIRST_PRIME), "prime below two")
    // flag RAM is only written during a rebuild, never while requests are open
    `ASSERT_NEVER(a_no_idle_write, i_clk, i_rst_n, mem_req.we && o_in_ready, "flag write while idle")
    // a result handed to the output register ends the transaction
    `ASSERT_CLK(a_take_to_idle, i_clk, i_rst_n, res_take |=> o_in_ready && o_out_valid, "result taken without return to idle")

endmodule
